// ===== rtl/assert_macros.svh =====
// Assertion macros included by the RTL back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet in reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet in reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/idbpm_pkg.sv =====
// Types, codes and helper functions for the ID3v2 tempo frame parser.
`timescale 1ns / 1ps

package idbpm_pkg;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_HDR  = 3'd1;
  localparam logic [2:0] ST_BAD_VER = 3'd2;
  localparam logic [2:0] ST_BAD_EXT = 3'd3;
  localparam logic [2:0] ST_NO_FRM  = 3'd4;
  localparam logic [2:0] ST_BAD_TXT = 3'd5;

  typedef struct packed {
    logic dig;
    logic dot;
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_t       cls;
  } beat_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c.dig = (b >= 8'h30) && (b <= 8'h39);
    c.dot = (b == 8'h2E);
    return c;
  endfunction

  // Drop bit 7 of each byte of a synchsafe word.
  function automatic logic [27:0] unsync7(input logic [31:0] a);
    return {a[30:24], a[22:16], a[14:8], a[6:0]};
  endfunction

endpackage

// ===== rtl/id3v2_bpm_frame_parser.sv =====
// Top level of the ID3v2 tempo frame parser.
//
//   channel | signals                          | direction
//   in      | in_valid/in_ready, data_byte, last_byte | byte beats in, file order
//   out     | out_valid/out_ready, found, bpm, status  | one result per stream
//
// One byte is taken per cycle while the input queue has room; a result appears in the cycle
// after the last byte leaves the two-entry input queue.
// The walker itself updates counters and shift registers once per beat.
// rst clears the queue, the parser and the result register; no clearing pass.
// A result not yet taken holds the last byte of the next stream in the queue;
// once the queue is full the input stalls too.
`timescale 1ns / 1ps

module id3v2_bpm_frame_parser
  import idbpm_pkg::*;
#(
  parameter int BPM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [15:0] bpm,
  output logic [2:0]  status
);

  logic  q_valid;
  logic  q_pop;
  beat_t q_beat;

  idbpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_valid   (q_valid),
    .q_beat    (q_beat),
    .q_pop     (q_pop)
  );

  idbpm_back #(
    .BPM_BITS (BPM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_beat    (q_beat),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .found     (found),
    .bpm       (bpm),
    .status    (status)
  );

endmodule

// ===== rtl/idbpm_front.sv =====
// Front end: takes byte beats, classifies them and queues them for the parser.
`timescale 1ns / 1ps

module idbpm_front
  import idbpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       q_valid,
  output beat_t      q_beat,
  input  logic       q_pop
);

  beat_t           mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            push;
  beat_t           beat_in;

  assign in_ready = (count != (Q_AW+1)'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_beat   = mem[rd_ptr];

  always_comb begin
    beat_in.data = data_byte;
    beat_in.last = last_byte;
    beat_in.cls  = classify(data_byte);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= beat_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(q_pop);
    end
  end

endmodule

// ===== rtl/idbpm_back.sv =====
// Back end: tag/frame walker, tempo text decoder and result register.
`timescale 1ns / 1ps

module idbpm_back
  import idbpm_pkg::*;
#(
  parameter int BPM_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  beat_t       q_beat,
  output logic        q_pop,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        found,
  output logic [15:0] bpm,
  output logic [2:0]  status
);

  `include "assert_macros.svh"

  localparam logic [2:0] PH_HDR   = 3'd0;
  localparam logic [2:0] PH_EXT   = 3'd1;
  localparam logic [2:0] PH_SKIPX = 3'd2;
  localparam logic [2:0] PH_FHDR  = 3'd3;
  localparam logic [2:0] PH_SKIPB = 3'd4;
  localparam logic [2:0] PH_BODY  = 3'd5;

  localparam logic [BPM_BITS-1:0] BpmMax = '1;

  // parser state
  logic [2:0]          phase, phase_next;
  logic [28:0]         off, off_next;
  logic [2:0]          ver, ver_next;
  logic                ext_flag, ext_flag_next;
  logic [28:0]         limit, limit_next;
  logic [31:0]         sacc, sacc_next;
  logic [31:0]         fid, fid_next;
  logic [3:0]          fk, fk_next;
  logic [32:0]         nfo, nfo_next;
  logic [1:0]          enc, enc_next;
  logic                u_pend, u_pend_next;
  logic                u_be, u_be_next;
  logic                u_first, u_first_next;
  logic                u_enc, u_enc_next;
  logic [7:0]          pbyte, pbyte_next;
  logic [BPM_BITS-1:0] acc, acc_next;
  logic                n_start, n_start_next;
  logic                n_dot, n_dot_next;
  logic                n_stop, n_stop_next;
  logic                n_nz, n_nz_next;
  logic                n_frac, n_frac_next;
  logic                n_rup, n_rup_next;
  logic                settled, settled_next;
  logic [2:0]          o_st, o_st_next;
  logic                o_fnd, o_fnd_next;
  logic [BPM_BITS-1:0] o_val, o_val_next;

  // working values
  logic [7:0]          bd;
  logic [29:0]         off1;
  logic [3:0]          hdr_len;
  logic [2:0]          id_len;
  logic [28:0]         lim_n;
  logic                bf_req;
  logic [32:0]         bf_pos;
  logic [33:0]         bf_end;
  logic [32:0]         np;
  logic [27:0]         ext_sz;
  logic [31:0]         fsz;
  logic [32:0]         body;
  logic [32:0]         fend;
  logic                ch_ok;
  logic                c_dig;
  logic                c_dot;
  logic [3:0]          c_d;
  logic [7:0]          lo_b;
  logic [7:0]          hi_b;
  cls_t                lo_cls;
  logic [BPM_BITS+3:0] prod;
  logic [BPM_BITS:0]   fin;
  logic [2:0]          r_st;
  logic                r_fnd;
  logic [BPM_BITS-1:0] r_val;
  logic [BPM_BITS+15:0] r_wide;
  logic                take_last;

  assign q_pop     = q_valid && (!q_beat.last || !res_valid || res_ready);
  assign take_last = q_pop && q_beat.last;
  assign bd        = q_beat.data;
  assign off1      = {1'b0, off} + 30'd1;
  assign hdr_len   = (ver == 3'd2) ? 4'd6 : 4'd10;
  assign id_len    = (ver == 3'd2) ? 3'd3 : 3'd4;

  always_comb begin
    phase_next    = phase;
    off_next      = off;
    ver_next      = ver;
    ext_flag_next = ext_flag;
    limit_next    = limit;
    sacc_next     = sacc;
    fid_next      = fid;
    fk_next       = fk;
    nfo_next      = nfo;
    enc_next      = enc;
    u_pend_next   = u_pend;
    u_be_next     = u_be;
    u_first_next  = u_first;
    u_enc_next    = u_enc;
    pbyte_next    = pbyte;
    acc_next      = acc;
    n_start_next  = n_start;
    n_dot_next    = n_dot;
    n_stop_next   = n_stop;
    n_nz_next     = n_nz;
    n_frac_next   = n_frac;
    n_rup_next    = n_rup;
    settled_next  = settled;
    o_st_next     = o_st;
    o_fnd_next    = o_fnd;
    o_val_next    = o_val;
    lim_n         = '0;
    bf_req        = 1'b0;
    bf_pos        = '0;
    bf_end        = '0;
    np            = '0;
    ext_sz        = '0;
    fsz           = '0;
    body          = '0;
    fend          = '0;
    ch_ok         = 1'b0;
    c_dig         = 1'b0;
    c_dot         = 1'b0;
    c_d           = bd[3:0];
    lo_b          = '0;
    hi_b          = '0;
    lo_cls        = '0;
    prod          = '0;
    fin           = '0;

    if (q_pop && !settled) begin
      off_next = off1[28:0];
      unique case (phase)
        PH_HDR: begin
          if ((off == 29'd0 && bd != 8'h49) || (off == 29'd1 && bd != 8'h44) ||
              (off == 29'd2 && bd != 8'h33)) begin
            settled_next = 1'b1;
            o_st_next    = ST_NO_HDR;
          end else begin
            if (off == 29'd3) begin
              ver_next = (bd >= 8'd2 && bd <= 8'd4) ? bd[2:0] : 3'd0;
            end else if (off == 29'd5) begin
              ext_flag_next = bd[6];
            end else if (off >= 29'd6) begin
              sacc_next = {sacc[23:0], bd};
            end
            if (off == 29'd9) begin
              if (ver == 3'd0) begin
                settled_next = 1'b1;
                o_st_next    = ST_BAD_VER;
              end else begin
                lim_n      = 29'd10 + {1'b0, unsync7(sacc_next)};
                limit_next = lim_n;
                sacc_next  = '0;
                if (ver != 3'd2 && ext_flag) begin
                  if (lim_n < 29'd14) begin
                    settled_next = 1'b1;
                    o_st_next    = ST_BAD_EXT;
                  end else begin
                    phase_next = PH_EXT;
                  end
                end else begin
                  bf_req = 1'b1;
                  bf_pos = 33'd10;
                end
              end
            end
          end
        end
        PH_EXT: begin
          sacc_next = {sacc[23:0], bd};
          if (off >= 29'd13) begin
            ext_sz = unsync7(sacc_next);
            if (ver == 3'd4 && ext_sz < 28'd6) begin
              settled_next = 1'b1;
              o_st_next    = ST_BAD_EXT;
            end else begin
              if (ver == 3'd4) begin
                np = 33'd10 + {5'b0, ext_sz};
              end else begin
                np = 33'd14 + {1'b0, sacc_next};
              end
              if (np > {4'b0, limit}) begin
                settled_next = 1'b1;
                o_st_next    = ST_BAD_EXT;
              end else if (np <= {3'b0, off1}) begin
                bf_req = 1'b1;
                bf_pos = np;
              end else begin
                nfo_next   = np;
                phase_next = PH_SKIPX;
              end
            end
          end
        end
        PH_SKIPX, PH_SKIPB: begin
          if ({3'b0, off1} >= nfo) begin
            bf_req = 1'b1;
            bf_pos = nfo;
          end
        end
        PH_FHDR: begin
          if (fk == 4'd0 && bd == 8'h00) begin
            settled_next = 1'b1;
            o_st_next    = ST_NO_FRM;
          end else begin
            fk_next = fk + 4'd1;
            if (fk < {1'b0, id_len}) begin
              fid_next = {fid[23:0], bd};
            end else if (fk < {id_len, 1'b0}) begin
              sacc_next = {sacc[23:0], bd};
            end
            if (fk + 4'd1 >= hdr_len) begin
              if (ver == 3'd2) begin
                fsz = {8'b0, sacc_next[23:0]};
              end else if (ver == 3'd3) begin
                fsz = sacc_next;
              end else begin
                fsz = {4'b0, unsync7(sacc_next)};
              end
              body = nfo + {29'b0, hdr_len};
              fend = body + {1'b0, fsz};
              if (fsz == '0 || fend > {4'b0, limit}) begin
                settled_next = 1'b1;
                o_st_next    = ST_NO_FRM;
              end else begin
                nfo_next = fend;
                if ((ver == 3'd2) ? (fid_next[23:0] == 24'h544250)
                                  : (fid_next == 32'h5442504D)) begin
                  phase_next = PH_BODY;
                end else begin
                  phase_next = PH_SKIPB;
                end
                u_pend_next  = 1'b0;
                u_be_next    = 1'b0;
                u_first_next = 1'b0;
                u_enc_next   = 1'b0;
                pbyte_next   = '0;
                enc_next     = '0;
                acc_next     = '0;
                n_start_next = 1'b0;
                n_dot_next   = 1'b0;
                n_stop_next  = 1'b0;
                n_nz_next    = 1'b0;
                n_frac_next  = 1'b0;
                n_rup_next   = 1'b0;
              end
            end
          end
        end
        PH_BODY: begin
          if (!u_enc) begin
            u_enc_next = 1'b1;
            enc_next   = (bd <= 8'd2) ? bd[1:0] : 2'd3;
            if (bd == 8'd2) begin
              u_be_next = 1'b1;
            end
          end else if (enc == 2'd0 || enc == 2'd3) begin
            ch_ok = 1'b1;
            c_dig = q_beat.cls.dig;
            c_dot = q_beat.cls.dot;
          end else if (!u_pend) begin
            u_pend_next = 1'b1;
            pbyte_next  = bd;
          end else begin
            u_pend_next = 1'b0;
            if (enc == 2'd1 && !u_first) begin
              u_first_next = 1'b1;
            end
            // byte-order mark only as the first unit of a UTF-16 body
            if (enc == 2'd1 && !u_first && pbyte == 8'hFF && bd == 8'hFE) begin
              ch_ok = 1'b0;
            end else if (enc == 2'd1 && !u_first && pbyte == 8'hFE && bd == 8'hFF) begin
              u_be_next = 1'b1;
            end else begin
              lo_b   = u_be ? bd : pbyte;
              hi_b   = u_be ? pbyte : bd;
              lo_cls = classify(lo_b);
              ch_ok  = 1'b1;
              c_dig  = lo_cls.dig && (hi_b == 8'h00);
              c_dot  = lo_cls.dot && (hi_b == 8'h00);
              c_d    = lo_b[3:0];
            end
          end

          if (ch_ok && !n_stop && (n_start || c_dig)) begin
            n_start_next = 1'b1;
            if (c_dig) begin
              if (c_d != 4'd0) begin
                n_nz_next = 1'b1;
              end
              if (n_dot) begin
                if (!n_frac) begin
                  n_frac_next = 1'b1;
                  n_rup_next  = (c_d >= 4'd5);
                end
              end else begin
                prod = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {{BPM_BITS{1'b0}}, c_d};
                acc_next = (prod > {4'b0, BpmMax}) ? BpmMax : prod[BPM_BITS-1:0];
              end
            end else if (c_dot && !n_dot) begin
              n_dot_next = 1'b1;
            end else begin
              n_stop_next = 1'b1;
            end
          end

          if ({3'b0, off1} >= nfo) begin
            settled_next = 1'b1;
            if (!n_start_next || !n_nz_next) begin
              o_st_next = ST_BAD_TXT;
            end else begin
              fin        = {1'b0, acc_next} + {{BPM_BITS{1'b0}}, n_rup_next};
              o_st_next  = ST_OK;
              o_fnd_next = 1'b1;
              o_val_next = fin[BPM_BITS] ? BpmMax : fin[BPM_BITS-1:0];
            end
          end
        end
        default: begin
          settled_next = 1'b1;
          o_st_next    = ST_NO_HDR;
        end
      endcase

      // start of a frame header, or the tag ends first
      if (bf_req) begin
        bf_end = {1'b0, bf_pos} + {30'b0, hdr_len};
        if (bf_end > {5'b0, limit_next}) begin
          settled_next = 1'b1;
          o_st_next    = ST_NO_FRM;
        end else begin
          phase_next = PH_FHDR;
          nfo_next   = bf_pos;
          sacc_next  = '0;
          fid_next   = '0;
          fk_next    = '0;
        end
      end
    end
  end

  // outcome of a stream ending on this beat
  always_comb begin
    r_fnd = 1'b0;
    r_val = '0;
    if (settled_next) begin
      r_st  = o_st_next;
      r_fnd = o_fnd_next;
      r_val = o_fnd_next ? o_val_next : '0;
    end else if (phase_next == PH_HDR) begin
      r_st = ST_NO_HDR;
    end else if (phase_next == PH_EXT || phase_next == PH_SKIPX) begin
      r_st = ST_BAD_EXT;
    end else begin
      r_st = ST_NO_FRM;
    end
    r_wide = {16'b0, r_val};
  end

  always_ff @(posedge clk) begin
    if (rst || take_last) begin
      phase    <= PH_HDR;
      off      <= '0;
      ver      <= '0;
      ext_flag <= 1'b0;
      limit    <= '0;
      sacc     <= '0;
      fid      <= '0;
      fk       <= '0;
      nfo      <= '0;
      enc      <= '0;
      u_pend   <= 1'b0;
      u_be     <= 1'b0;
      u_first  <= 1'b0;
      u_enc    <= 1'b0;
      pbyte    <= '0;
      acc      <= '0;
      n_start  <= 1'b0;
      n_dot    <= 1'b0;
      n_stop   <= 1'b0;
      n_nz     <= 1'b0;
      n_frac   <= 1'b0;
      n_rup    <= 1'b0;
      settled  <= 1'b0;
      o_st     <= ST_OK;
      o_fnd    <= 1'b0;
      o_val    <= '0;
    end else begin
      phase    <= phase_next;
      off      <= off_next;
      ver      <= ver_next;
      ext_flag <= ext_flag_next;
      limit    <= limit_next;
      sacc     <= sacc_next;
      fid      <= fid_next;
      fk       <= fk_next;
      nfo      <= nfo_next;
      enc      <= enc_next;
      u_pend   <= u_pend_next;
      u_be     <= u_be_next;
      u_first  <= u_first_next;
      u_enc    <= u_enc_next;
      pbyte    <= pbyte_next;
      acc      <= acc_next;
      n_start  <= n_start_next;
      n_dot    <= n_dot_next;
      n_stop   <= n_stop_next;
      n_nz     <= n_nz_next;
      n_frac   <= n_frac_next;
      n_rup    <= n_rup_next;
      settled  <= settled_next;
      o_st     <= o_st_next;
      o_fnd    <= o_fnd_next;
      o_val    <= o_val_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take_last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      found  <= r_fnd;
      bpm    <= r_wide[15:0];
      status <= r_st;
    end
  end

  `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
  `ASSERT_IMPL(a_found_ok, res_valid && found, status == ST_OK, "found with error status")
  `ASSERT_IMPL(a_miss_zero, res_valid && !found, bpm == 16'd0, "tempo nonzero when not found")

endmodule

// ===== sim/id3v2_bpm_frame_parser_checker.sv =====
// Watches both channels of the tempo frame parser, predicts each result and compares.
`timescale 1ns / 1ps

module id3v2_bpm_frame_parser_checker
  import idbpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        found,
  input  logic [15:0] bpm,
  input  logic [2:0]  status,
  output int          fails,
  output int          pending,
  output int          results
);

  typedef enum logic [3:0] {
    W_HDR, W_EXT, W_SKIPX, W_FHDR, W_SKIPB, W_BODY
  } walk_phase_t;

  typedef struct {
    logic        found;
    logic [15:0] bpm;
    logic [2:0]  status;
  } tempo_result_t;

  localparam longint unsigned TEMPO_MAX = 65535;

  tempo_result_t expected_tempos[$];

  int              fail_cnt = 0;
  int              res_cnt = 0;

  walk_phase_t     phase;
  logic [28:0]     offset;
  int              ver;
  logic [7:0]      hflags;
  longint unsigned tag_end;
  logic [31:0]     size_sr;
  logic [31:0]     id_sr;
  longint unsigned next_pos;
  int              enc;
  bit              u_pend, u_be, u_first, u_enc;
  logic [7:0]      u_byte;
  longint unsigned int_acc;
  bit              n_start, n_dot, n_stop, n_nz, n_frac, n_rup;
  bit              done;
  logic [2:0]      d_status;
  bit              d_found;
  longint unsigned d_bpm;

  function automatic logic [31:0] drop_sync_bits(logic [31:0] a);
    logic [31:0] r;
    r = {4'd0, a[30:24], a[22:16], a[14:8], a[6:0]};
    return r;
  endfunction

  task automatic clear_walker();
    phase = W_HDR; offset = '0; ver = 0; hflags = '0; tag_end = 0;
    size_sr = '0; id_sr = '0; next_pos = 0; enc = 0;
    u_pend = 0; u_be = 0; u_first = 0; u_enc = 0; u_byte = '0;
    int_acc = 0;
    {n_start, n_dot, n_stop, n_nz, n_frac, n_rup} = '0;
    done = 0; d_status = ST_OK; d_found = 0; d_bpm = 0;
  endtask

  task automatic settle(logic [2:0] st, bit f, longint unsigned v);
    done = 1; d_status = st; d_found = f; d_bpm = v;
  endtask

  task automatic open_frame(longint unsigned pos);
    longint unsigned hlen;
    hlen = (ver == 2) ? 6 : 10;
    if (pos + hlen > tag_end) begin
      settle(ST_NO_FRM, 0, 0);
      return;
    end
    phase = W_FHDR; next_pos = pos; size_sr = '0; id_sr = '0;
  endtask

  task automatic take_char(int c);
    bit dig;
    int d;
    dig = (c >= 8'h30) && (c <= 8'h39);
    d = c - 8'h30;
    if (n_stop) return;
    if (!n_start) begin
      if (!dig) return;
      n_start = 1;
    end
    if (dig) begin
      if (d != 0) n_nz = 1;
      if (n_dot) begin
        if (!n_frac) begin
          n_frac = 1;
          if (d >= 5) n_rup = 1;
        end
      end else begin
        int_acc = int_acc * 10 + d;
        if (int_acc > TEMPO_MAX) int_acc = TEMPO_MAX;
      end
    end else if (c == 8'h2E && !n_dot) begin
      n_dot = 1;
    end else begin
      n_stop = 1;
    end
  endtask

  task automatic take_text(logic [7:0] b);
    logic [7:0] p;
    if (enc == 0 || enc == 3) begin
      take_char(b < 8'h80 ? int'(b) : 256);
      return;
    end
    if (!u_pend) begin
      u_pend = 1; u_byte = b;
      return;
    end
    p = u_byte;
    u_pend = 0;
    if (enc == 1 && !u_first) begin
      u_first = 1;
      if (p == 8'hFF && b == 8'hFE) return;
      if (p == 8'hFE && b == 8'hFF) begin
        u_be = 1;
        return;
      end
    end
    take_char(u_be ? int'({p, b}) : int'({b, p}));
  endtask

  task automatic close_body();
    longint unsigned v;
    if (!n_start || !n_nz) begin
      settle(ST_BAD_TXT, 0, 0);
      return;
    end
    v = int_acc + (n_rup ? 1 : 0);
    if (v > TEMPO_MAX) v = TEMPO_MAX;
    settle(ST_OK, 1, v);
  endtask

  task automatic walk(logic [7:0] b);
    longint unsigned off, np, k, idn, hlen, body, sz;
    logic [31:0] e;
    bit hit;
    off = offset;
    case (phase)
      W_HDR: begin
        if ((off == 0 && b != 8'h49) || (off == 1 && b != 8'h44) ||
            (off == 2 && b != 8'h33)) begin
          settle(ST_NO_HDR, 0, 0);
          return;
        end
        if (off == 3) ver = (b >= 2 && b <= 4) ? int'(b) : 0;
        else if (off == 5) hflags = b;
        else if (off >= 6) size_sr = {size_sr[23:0], b};
        if (off == 9) begin
          if (ver == 0) begin
            settle(ST_BAD_VER, 0, 0);
            return;
          end
          tag_end = 10 + drop_sync_bits(size_sr);
          size_sr = '0;
          if (ver != 2 && hflags[6]) begin
            if (tag_end < 14) settle(ST_BAD_EXT, 0, 0);
            else phase = W_EXT;
          end else begin
            open_frame(10);
          end
        end
      end
      W_EXT: begin
        size_sr = {size_sr[23:0], b};
        if (off >= 13) begin
          if (ver == 4) begin
            e = drop_sync_bits(size_sr);
            if (e < 6) begin
              settle(ST_BAD_EXT, 0, 0);
              return;
            end
            np = 10 + longint'(e);
          end else begin
            np = 14 + longint'(size_sr);
          end
          if (np > tag_end) begin
            settle(ST_BAD_EXT, 0, 0);
            return;
          end
          if (np <= off + 1) open_frame(np);
          else begin
            next_pos = np;
            phase = W_SKIPX;
          end
        end
      end
      W_SKIPX, W_SKIPB: begin
        if (off + 1 >= next_pos) open_frame(next_pos);
      end
      W_FHDR: begin
        k = off - next_pos;
        idn = (ver == 2) ? 3 : 4;
        hlen = (ver == 2) ? 6 : 10;
        if (k == 0 && b == 8'h00) begin
          settle(ST_NO_FRM, 0, 0);
          return;
        end
        if (k < idn) id_sr = {id_sr[23:0], b};
        else if (k < idn + idn) size_sr = {size_sr[23:0], b};
        if (k + 1 >= hlen) begin
          body = next_pos + hlen;
          if (ver == 2) sz = size_sr[23:0];
          else if (ver == 3) sz = size_sr;
          else sz = drop_sync_bits(size_sr);
          if (sz == 0 || body + sz > tag_end) begin
            settle(ST_NO_FRM, 0, 0);
            return;
          end
          hit = (ver == 2) ? (id_sr == 32'h00544250) : (id_sr == 32'h5442504D);
          next_pos = body + sz;
          phase = hit ? W_BODY : W_SKIPB;
          u_pend = 0; u_be = 0; u_first = 0; u_enc = 0; u_byte = '0;
          enc = 0; int_acc = 0;
          {n_start, n_dot, n_stop, n_nz, n_frac, n_rup} = '0;
        end
      end
      W_BODY: begin
        if (!u_enc) begin
          u_enc = 1;
          enc = (b <= 2) ? int'(b) : 3;
          if (enc == 2) u_be = 1;
        end else begin
          take_text(b);
        end
        if (off + 1 >= next_pos) close_body();
      end
      default: settle(ST_NO_HDR, 0, 0);
    endcase
  endtask

  task automatic tempo_step(logic [7:0] b, logic lst);
    tempo_result_t r;
    if (!done) begin
      walk(b);
      offset = offset + 1'b1;
    end
    if (!lst) return;
    if (!done) begin
      if (phase == W_HDR) settle(ST_NO_HDR, 0, 0);
      else if (phase == W_EXT || phase == W_SKIPX) settle(ST_BAD_EXT, 0, 0);
      else settle(ST_NO_FRM, 0, 0);
    end
    r.found = d_found;
    r.bpm = d_found ? d_bpm[15:0] : 16'd0;
    r.status = d_status;
    expected_tempos.push_back(r);
    clear_walker();
  endtask

  assign pending = expected_tempos.size();
  assign fails   = fail_cnt;
  assign results = res_cnt;

  always @(posedge clk) begin
    tempo_result_t x;
    int errs;
    if (rst) begin
      clear_walker();
    end else begin
      errs = 0;
      if (in_valid && in_ready) tempo_step(data_byte, last_byte);
      if (out_valid && out_ready) begin
        res_cnt <= res_cnt + 1;
        if (expected_tempos.size() == 0) begin
          $error("result with nothing expected: found=%0d bpm=%0d status=%0d",
                 found, bpm, status);
          errs++;
        end else begin
          x = expected_tempos.pop_front();
          if (found !== x.found) begin
            $error("found: expected %0d, got %0d", x.found, found);
            errs++;
          end
          if (bpm !== x.bpm) begin
            $error("bpm: expected %0d, got %0d", x.bpm, bpm);
            errs++;
          end
          if (status !== x.status) begin
            $error("status: expected %0d, got %0d", x.status, status);
            errs++;
          end
        end
        fail_cnt <= fail_cnt + errs;
      end
    end
  end

endmodule

// ===== sim/tb_id3v2_bpm_frame_parser.sv =====
// Stimulus and verdict for the ID3v2 tempo frame parser testbench.
`timescale 1ns / 1ps

module tb_id3v2_bpm_frame_parser;
  import idbpm_pkg::*;

  localparam int TARGET_BYTES = 1250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;

  logic        clk, rst;
  logic        in_valid, in_ready, last_byte;
  logic [7:0]  data_byte;
  logic        out_valid, out_ready, found;
  logic [15:0] bpm;
  logic [2:0]  status;
  int          fails, pending, results;

  bit          idle_on = 0;
  int          cycles = 0;
  int          sent = 0;
  int          streams = 0;

  logic [7:0]  strm[$];
  logic [7:0]  area[$];
  logic [7:0]  fbody[$];

  string texts[17] = '{"120", "128.5", "99.49", "  75.5bpm", "0", "0.0", "0.5", "",
                       "abc", "1.2.3", "9999999", "65535.5", ".7", "007", "x12 3",
                       "140.", "3.14159"};

  id3v2_bpm_frame_parser dut (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .last_byte,
    .out_valid, .out_ready, .found, .bpm, .status
  );

  id3v2_bpm_frame_parser_checker chk (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .last_byte,
    .out_valid, .out_ready, .found, .bpm, .status, .fails, .pending, .results
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when random traffic starts.
  initial begin
    int stall;
    bit held;
    out_ready = 0;
    stall = 0;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (idle_on && !held) begin
        held = 1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && idle_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 5);
      end
      out_ready <= (stall == 0);
      if (stall > 0) stall--;
      @(negedge clk);
    end
  end

  task automatic put32(logic [31:0] v);
    area.push_back(v[31:24]); area.push_back(v[23:16]);
    area.push_back(v[15:8]);  area.push_back(v[7:0]);
  endtask

  function automatic logic [31:0] to_sync(int unsigned v);
    return {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]};
  endfunction

  // Frame header plus body into the frame area; zsz forces a zero size.
  task automatic put_frame(int ver, logic [31:0] id, bit zsz);
    int unsigned sz;
    sz = zsz ? 0 : fbody.size();
    if (ver == 2) begin
      area.push_back(id[23:16]); area.push_back(id[15:8]); area.push_back(id[7:0]);
      area.push_back(sz[23:16]); area.push_back(sz[15:8]); area.push_back(sz[7:0]);
    end else begin
      put32(id);
      put32(ver == 3 ? sz : to_sync(sz));
      area.push_back(8'h00); area.push_back(8'h00);
    end
    if (!zsz) foreach (fbody[i]) area.push_back(fbody[i]);
  endtask

  // Tempo body: encoding byte, then text; bom 0 none, 1 little, 2 big.
  task automatic tempo_body(int encb, string s, int bom, bit odd, bit wide_junk);
    bit be;
    logic [7:0] c;
    fbody.delete();
    fbody.push_back(encb[7:0]);
    be = (encb == 2) || (encb == 1 && bom == 2);
    if (encb == 1 && bom == 1) begin fbody.push_back(8'hFF); fbody.push_back(8'hFE); end
    if (encb == 1 && bom == 2) begin fbody.push_back(8'hFE); fbody.push_back(8'hFF); end
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (encb == 1 || encb == 2) begin
        if (be) begin fbody.push_back(wide_junk && i == 0 ? 8'h01 : 8'h00); fbody.push_back(c); end
        else begin fbody.push_back(c); fbody.push_back(wide_junk && i == 0 ? 8'h01 : 8'h00); end
      end else begin
        fbody.push_back((wide_junk && i == 0) ? (c | 8'h80) : c);
      end
    end
    if (odd) fbody.push_back(8'h35);
  endtask

  // ext: 0 none, 1 valid, 2 bad size. delta nudges the tag size.
  task automatic make_tag(int ver, int ext, int txt, int encb, int bom, bit zsz,
                          int pad, int delta, int dummies);
    logic [7:0] flg;
    logic [31:0] id;
    int n, tsz, extn;
    area.delete();
    strm.delete();
    extn = 0;
    if (ext != 0 && ver != 2) begin
      if (ver == 4) begin
        n = (ext == 1) ? $urandom_range(6, 8) : $urandom_range(0, 5);
        put32(to_sync(n));
        for (int i = 4; i < n; i++) area.push_back(8'($urandom));
      end else begin
        n = (ext == 1) ? $urandom_range(0, 3) : $urandom_range(200, 400);
        put32(n);
        if (ext == 1) for (int i = 0; i < n; i++) area.push_back(8'($urandom));
      end
    end
    for (int f = 0; f < dummies; f++) begin
      id = {8'h58, 8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
            8'($urandom_range(48, 90))};
      if (ver == 2) id = {8'h00, id[31:8]};
      fbody.delete();
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) fbody.push_back(8'($urandom));
      put_frame(ver, id, 0);
    end
    if (txt >= 0) begin
      tempo_body(encb, texts[txt], bom, $urandom_range(0, 7) == 0,
                 $urandom_range(0, 9) == 0);
      put_frame(ver, ver == 2 ? 32'h00544250 : 32'h5442504D, zsz);
    end
    for (int i = 0; i < pad; i++) area.push_back(8'h00);
    tsz = area.size() + delta;
    if (tsz < 0) tsz = 0;
    flg = (8'($urandom) & 8'hBF) | (ext != 0 ? 8'h40 : 8'h00);
    strm.push_back(8'h49); strm.push_back(8'h44); strm.push_back(8'h33);
    strm.push_back(ver[7:0]); strm.push_back(8'($urandom)); strm.push_back(flg);
    id = to_sync(tsz);
    strm.push_back(id[31:24]); strm.push_back(id[23:16]);
    strm.push_back(id[15:8]); strm.push_back(id[7:0]);
    foreach (area[i]) strm.push_back(area[i]);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) strm.push_back(8'($urandom));
  endtask

  task automatic send_stream();
    for (int i = 0; i < strm.size(); i++) begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= strm[i];
      last_byte <= (i == strm.size() - 1);
      do @(posedge clk); while (!in_ready);
      sent++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
    streams++;
  endtask

  task automatic random_stream();
    int kind, ver, n;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      strm.delete();
      n = $urandom_range(1, 15);
      for (int i = 0; i < n; i++) strm.push_back(8'($urandom));
      if ($urandom_range(0, 1)) strm[0] = 8'h49;
    end else begin
      ver = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(2, 4);
      make_tag(ver, $urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0,
               $urandom_range(0, 9) == 0 ? -1 : $urandom_range(0, 16),
               $urandom_range(0, 4) == 4 ? $urandom_range(3, 255) : $urandom_range(0, 3),
               $urandom_range(0, 2), $urandom_range(0, 19) == 0,
               $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0,
               $urandom_range(0, 4) == 0 ? $urandom_range(0, 8) - 2 : 0,
               $urandom_range(0, 2));
      if (kind < 4 && strm.size() > 0)
        strm[$urandom_range(0, strm.size() - 1)] = 8'($urandom);
      if (kind == 4 && strm.size() > 2) strm = strm[0:$urandom_range(1, strm.size() - 2)];
    end
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    data_byte = '0;
    last_byte = 0;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: short stream, bad header, bad version, then tags.
    strm = '{8'h49};
    send_stream();
    strm = '{8'h49, 8'h44, 8'h34, 8'h03};
    send_stream();
    strm = '{8'h49, 8'h44, 8'h33, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_stream();
    make_tag(2, 0, 0, 0, 0, 0, 0, 0, 0);   // TBP, Latin-1
    send_stream();
    make_tag(3, 1, 10, 0, 0, 0, 2, 0, 1);  // extended header, saturation
    send_stream();
    make_tag(4, 2, 0, 0, 0, 0, 0, 0, 0);   // extended size below six
    send_stream();
    make_tag(4, 1, 1, 1, 2, 0, 0, 0, 0);   // UTF-16 big-endian BOM
    send_stream();
    make_tag(3, 0, 6, 1, 1, 0, 0, 0, 0);   // little-endian BOM, rounds up from zero
    send_stream();
    make_tag(4, 0, 2, 2, 0, 0, 0, 0, 0);   // big-endian, no BOM
    send_stream();
    make_tag(3, 0, 5, 200, 0, 0, 0, 0, 0); // encoding byte above three, all zero digits
    send_stream();
    make_tag(3, 0, 0, 0, 0, 1, 0, 0, 0);   // zero-sized frame
    send_stream();
    make_tag(4, 0, -1, 0, 0, 0, 3, 0, 1);  // padding, no tempo frame
    send_stream();
    make_tag(3, 0, 0, 0, 0, 0, 0, -3, 0);  // frame overruns the tag
    send_stream();

    idle_on = 1;
    while (sent < TARGET_BYTES) begin
      if (sent > TARGET_BYTES * 85 / 100) idle_on = 0;
      random_stream();
      send_stream();
    end
    idle_on = 0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d streams, %0d bytes, %0d results, with one long output hold-off.",
             streams, sent, results);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
